// ===== rtl/dhlt_pkg.sv =====
// dhlt_pkg: widths, fixed-point constants and shared types of the link transform
// the cordic arctangent table is built here at elaboration; no dependencies
`timescale 1ns / 1ps

package dhlt_pkg;

	localparam int TRIG_FRAC_BITS = 14;
	localparam int N_STEPS        = TRIG_FRAC_BITS + 2;
	localparam int SH_W           = $clog2(N_STEPS);
	localparam int XY_W           = TRIG_FRAC_BITS + 3;
	localparam int TR_W           = TRIG_FRAC_BITS + 2;
	localparam int Z_W            = 36;
	localparam int ANG_W          = 17;
	localparam int REM_W          = 14;
	localparam int Q14_W          = 16;
	localparam int FX_W           = 32;

	localparam longint DEG_RATIO  = 64'd7690109350;
	localparam longint GAIN_Q32   = 64'd2608131496;
	localparam longint X_START    =
		(GAIN_Q32 + (longint'(1) << (31 - TRIG_FRAC_BITS))) >> (32 - TRIG_FRAC_BITS);

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_90,
		QUAD_180,
		QUAD_270
	} quad_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} rot_t;

	typedef struct packed {
		quad_t                  q_th;
		quad_t                  q_al;
		logic                   ex_th;
		logic                   ex_al;
		logic signed [FX_W-1:0] r;
		logic signed [FX_W-1:0] d;
	} side_t;

	function automatic longint udiv_const(longint n, int dv);
		longint q;
		longint rem;
		q   = 0;
		rem = 0;
		for (int b = 63; b >= 0; b--) begin
			rem = (rem << 1) | ((n >> b) & longint'(1));
			if (rem >= longint'(dv)) begin
				rem = rem - longint'(dv);
				q   = q | (longint'(1) << b);
			end
		end
		return q;
	endfunction

	function automatic longint atan_step(int i);
		longint scaled;
		longint sum;
		longint term;
		int     k;
		scaled = DEG_RATIO << 24;
		sum    = 0;
		if (i == 0) begin
			return longint'(45) << 27;
		end
		for (k = 1; k * i < 64; k += 2) begin
			term = udiv_const(scaled >> (k * i), k);
			if (((k - 1) / 2) % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return sum >>> 24;
	endfunction

endpackage

// ===== rtl/dhlt_angle_reduce.sv =====
// dhlt_angle_reduce: wraps both angles, splits off the quadrant and seeds the cordic
// depends on dhlt_pkg
`timescale 1ns / 1ps

module dhlt_angle_reduce (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          up_valid,
	output logic                          up_stall,
	input  logic signed [dhlt_pkg::ANG_W-1:0] theta_angle,
	input  logic signed [dhlt_pkg::ANG_W-1:0] alpha_angle,
	input  logic signed [dhlt_pkg::FX_W-1:0]  link_offset,
	input  logic signed [dhlt_pkg::FX_W-1:0]  link_height,
	output logic                          dn_valid,
	input  logic                          dn_stall,
	output dhlt_pkg::rot_t                dn_th,
	output dhlt_pkg::rot_t                dn_al,
	output dhlt_pkg::side_t               dn_side
);
	import dhlt_pkg::*;

	typedef struct packed {
		quad_t                   q;
		logic                    ex;
		logic signed [REM_W-1:0] r;
	} red_t;

	localparam logic signed [17:0] FULL   = 18'sd46080;
	localparam logic signed [17:0] FULL2  = 18'sd92160;
	localparam logic signed [17:0] B0     = 18'sd5760;
	localparam logic signed [17:0] B1     = 18'sd17280;
	localparam logic signed [17:0] B2     = 18'sd28800;
	localparam logic signed [17:0] B3     = 18'sd40320;
	localparam logic signed [17:0] Q1     = 18'sd11520;
	localparam logic signed [17:0] Q2     = 18'sd23040;
	localparam logic signed [17:0] Q3     = 18'sd34560;

	function automatic red_t reduce(logic signed [ANG_W-1:0] ang);
		logic signed [17:0] a;
		logic signed [17:0] u;
		logic signed [17:0] rr;
		red_t o;
		a = 18'(ang);
		priority if (a >= FULL) begin
			u = a - FULL;
		end else if (a >= 18'sd0) begin
			u = a;
		end else if (a >= -FULL) begin
			u = a + FULL;
		end else begin
			u = a + FULL2;
		end
		priority if (u <= B0) begin
			o.q = QUAD_0;
			rr  = u;
		end else if (u <= B1) begin
			o.q = QUAD_90;
			rr  = u - Q1;
		end else if (u <= B2) begin
			o.q = QUAD_180;
			rr  = u - Q2;
		end else if (u <= B3) begin
			o.q = QUAD_270;
			rr  = u - Q3;
		end else begin
			o.q = QUAD_0;
			rr  = u - FULL;
		end
		o.r  = REM_W'(rr);
		o.ex = (rr == 18'sd0);
		return o;
	endfunction

	function automatic rot_t seed(red_t v);
		rot_t o;
		o.x = XY_W'(X_START);
		o.y = '0;
		o.z = Z_W'(v.r) <<< 20;
		return o;
	endfunction

	red_t  red_th;
	red_t  red_al;
	logic  valid_q;
	rot_t  th_q;
	rot_t  al_q;
	side_t side_q;

	always_comb begin
		red_th = reduce(theta_angle);
		red_al = reduce(alpha_angle);
	end

	assign up_stall = valid_q && dn_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!up_stall) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_stall && up_valid) begin
			th_q         <= seed(red_th);
			al_q         <= seed(red_al);
			side_q.q_th  <= red_th.q;
			side_q.q_al  <= red_al.q;
			side_q.ex_th <= red_th.ex;
			side_q.ex_al <= red_al.ex;
			side_q.r     <= link_offset;
			side_q.d     <= link_height;
		end
	end

	assign dn_valid = valid_q;
	assign dn_th    = th_q;
	assign dn_al    = al_q;
	assign dn_side  = side_q;

endmodule

// ===== rtl/dhlt_cordic_cell.sv =====
// dhlt_cordic_cell: one cordic micro-rotation for both angles, with its own word slot
// depends on dhlt_pkg; shift and arctangent come in as tied constants
`timescale 1ns / 1ps

module dhlt_cordic_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [dhlt_pkg::SH_W-1:0]       shamt,
	input  logic signed [dhlt_pkg::Z_W-1:0] atan,
	input  logic                            up_valid,
	output logic                            up_stall,
	input  dhlt_pkg::rot_t                  up_th,
	input  dhlt_pkg::rot_t                  up_al,
	input  dhlt_pkg::side_t                 up_side,
	output logic                            dn_valid,
	input  logic                            dn_stall,
	output dhlt_pkg::rot_t                  dn_th,
	output dhlt_pkg::rot_t                  dn_al,
	output dhlt_pkg::side_t                 dn_side
);
	import dhlt_pkg::*;

	function automatic rot_t rotate(rot_t v, logic [SH_W-1:0] sh, logic signed [Z_W-1:0] at);
		logic signed [XY_W-1:0] dx;
		logic signed [XY_W-1:0] dy;
		rot_t o;
		dx = v.y >>> sh;
		dy = v.x >>> sh;
		if (v.z >= 0) begin
			o.x = v.x - dx;
			o.y = v.y + dy;
			o.z = v.z - at;
		end else begin
			o.x = v.x + dx;
			o.y = v.y - dy;
			o.z = v.z + at;
		end
		return o;
	endfunction

	logic  valid_q;
	rot_t  th_q;
	rot_t  al_q;
	side_t side_q;

	assign up_stall = valid_q && dn_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!up_stall) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_stall && up_valid) begin
			th_q   <= rotate(up_th, shamt, atan);
			al_q   <= rotate(up_al, shamt, atan);
			side_q <= up_side;
		end
	end

	assign dn_valid = valid_q;
	assign dn_th    = th_q;
	assign dn_al    = al_q;
	assign dn_side  = side_q;

endmodule

// ===== rtl/dhlt_matrix_out.sv =====
// dhlt_matrix_out: quadrant fix-up, products and rounding of the eleven matrix terms
// depends on dhlt_pkg; three stages, the last one is the output register
`timescale 1ns / 1ps

module dhlt_matrix_out (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               up_valid,
	output logic                               up_stall,
	input  dhlt_pkg::rot_t                     up_th,
	input  dhlt_pkg::rot_t                     up_al,
	input  dhlt_pkg::side_t                    up_side,
	output logic                               dn_valid,
	input  logic                               dn_stall,
	output logic signed [dhlt_pkg::Q14_W-1:0]  row0_col0,
	output logic signed [dhlt_pkg::Q14_W-1:0]  row0_col1,
	output logic signed [dhlt_pkg::Q14_W-1:0]  row0_col2,
	output logic signed [dhlt_pkg::FX_W-1:0]   trans_x,
	output logic signed [dhlt_pkg::Q14_W-1:0]  row1_col0,
	output logic signed [dhlt_pkg::Q14_W-1:0]  row1_col1,
	output logic signed [dhlt_pkg::Q14_W-1:0]  row1_col2,
	output logic signed [dhlt_pkg::FX_W-1:0]   trans_y,
	output logic signed [dhlt_pkg::Q14_W-1:0]  row2_col1,
	output logic signed [dhlt_pkg::Q14_W-1:0]  row2_col2,
	output logic signed [dhlt_pkg::FX_W-1:0]   trans_z
);
	import dhlt_pkg::*;

	localparam int F      = TRIG_FRAC_BITS;
	localparam int PR_W   = 2 * TR_W;
	localparam int PW     = PR_W + 1;
	localparam int P_SH   = 2 * F - 14;
	localparam int SW     = TR_W + 8;
	localparam int S_SH   = (F >= 14) ? F - 14 : 0;
	localparam int S_UP   = (F < 14) ? 14 - F : 0;
	localparam int TP_W   = FX_W + TR_W;
	localparam int TW     = TP_W + 1;

	localparam logic signed [XY_W-1:0] ONE_XY = XY_W'(longint'(1) << F);
	localparam logic signed [TR_W-1:0] ONE_TR = TR_W'(longint'(1) << F);
	localparam logic signed [PW-1:0]   P_HALF = PW'(longint'(1) << (P_SH - 1));
	localparam logic signed [PW-1:0]   P_MAX  = PW'(16384);
	localparam logic signed [PW-1:0]   P_MIN  = -P_MAX;
	localparam logic signed [SW-1:0]   S_HALF = SW'((longint'(1) << S_SH) >> 1);
	localparam logic signed [SW-1:0]   S_MAX  = SW'(16384);
	localparam logic signed [SW-1:0]   S_MIN  = -S_MAX;
	localparam logic signed [TW-1:0]   T_HALF = TW'(longint'(1) << (F - 1));
	localparam logic signed [TW-1:0]   T_MAX  = TW'(longint'(32'h7fff_ffff));
	localparam logic signed [TW-1:0]   T_MIN  = -T_MAX - TW'(1);

	typedef struct packed {
		logic signed [TR_W-1:0] c;
		logic signed [TR_W-1:0] s;
	} trig_t;

	function automatic logic signed [TR_W-1:0] clamp_one(logic signed [XY_W-1:0] v);
		logic signed [TR_W-1:0] o;
		priority if (v > ONE_XY) begin
			o = ONE_TR;
		end else if (v < -ONE_XY) begin
			o = -ONE_TR;
		end else begin
			o = TR_W'(v);
		end
		return o;
	endfunction

	function automatic trig_t fix_quad(rot_t v, quad_t q, logic ex);
		logic signed [TR_W-1:0] cc;
		logic signed [TR_W-1:0] ss;
		trig_t o;
		if (ex) begin
			cc = ONE_TR;
			ss = '0;
		end else begin
			cc = clamp_one(v.x);
			ss = clamp_one(v.y);
		end
		unique case (q)
			QUAD_0: begin
				o.c = cc;
				o.s = ss;
			end
			QUAD_90: begin
				o.c = -ss;
				o.s = cc;
			end
			QUAD_180: begin
				o.c = -cc;
				o.s = -ss;
			end
			QUAD_270: begin
				o.c = ss;
				o.s = -cc;
			end
			default: begin
				o.c = cc;
				o.s = ss;
			end
		endcase
		return o;
	endfunction

	function automatic logic signed [Q14_W-1:0] prod_round(logic signed [PR_W-1:0] p, logic neg);
		logic signed [PW-1:0] e;
		logic signed [PW-1:0] rr;
		logic signed [PW-1:0] o;
		e = PW'(p);
		if (neg) begin
			e = -e;
		end
		rr = (e + P_HALF) >>> P_SH;
		priority if (rr > P_MAX) begin
			o = P_MAX;
		end else if (rr < P_MIN) begin
			o = P_MIN;
		end else begin
			o = rr;
		end
		return Q14_W'(o);
	endfunction

	function automatic logic signed [Q14_W-1:0] sgl_round(logic signed [TR_W-1:0] v);
		logic signed [SW-1:0] e;
		logic signed [SW-1:0] rr;
		logic signed [SW-1:0] o;
		e  = SW'(v);
		rr = ((e + S_HALF) >>> S_SH) <<< S_UP;
		priority if (rr > S_MAX) begin
			o = S_MAX;
		end else if (rr < S_MIN) begin
			o = S_MIN;
		end else begin
			o = rr;
		end
		return Q14_W'(o);
	endfunction

	function automatic logic signed [FX_W-1:0] trans_round(logic signed [TP_W-1:0] p);
		logic signed [TW-1:0] e;
		logic signed [TW-1:0] rr;
		logic signed [TW-1:0] o;
		e  = TW'(p);
		rr = (e + T_HALF) >>> F;
		priority if (rr > T_MAX) begin
			o = T_MAX;
		end else if (rr < T_MIN) begin
			o = T_MIN;
		end else begin
			o = rr;
		end
		return FX_W'(o);
	endfunction

	logic stall_s1;
	logic stall_s2;
	logic stall_s3;
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;

	trig_t tth;
	trig_t tal;

	logic signed [TR_W-1:0] ct_s1;
	logic signed [TR_W-1:0] st_s1;
	logic signed [TR_W-1:0] ca_s1;
	logic signed [TR_W-1:0] sa_s1;
	logic signed [FX_W-1:0] r_s1;
	logic signed [FX_W-1:0] d_s1;

	logic signed [PR_W-1:0] stca_s2;
	logic signed [PR_W-1:0] stsa_s2;
	logic signed [PR_W-1:0] ctca_s2;
	logic signed [PR_W-1:0] ctsa_s2;
	logic signed [TP_W-1:0] tx_s2;
	logic signed [TP_W-1:0] ty_s2;
	logic signed [TR_W-1:0] ct_s2;
	logic signed [TR_W-1:0] st_s2;
	logic signed [TR_W-1:0] ca_s2;
	logic signed [TR_W-1:0] sa_s2;
	logic signed [FX_W-1:0] d_s2;

	logic signed [Q14_W-1:0] r00_s3;
	logic signed [Q14_W-1:0] r01_s3;
	logic signed [Q14_W-1:0] r02_s3;
	logic signed [FX_W-1:0]  tx_s3;
	logic signed [Q14_W-1:0] r10_s3;
	logic signed [Q14_W-1:0] r11_s3;
	logic signed [Q14_W-1:0] r12_s3;
	logic signed [FX_W-1:0]  ty_s3;
	logic signed [Q14_W-1:0] r21_s3;
	logic signed [Q14_W-1:0] r22_s3;
	logic signed [FX_W-1:0]  tz_s3;

	assign stall_s3 = valid_s3 && dn_stall;
	assign stall_s2 = valid_s2 && stall_s3;
	assign stall_s1 = valid_s1 && stall_s2;
	assign up_stall = stall_s1;

	always_comb begin
		tth = fix_quad(up_th, up_side.q_th, up_side.ex_th);
		tal = fix_quad(up_al, up_side.q_al, up_side.ex_al);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (!stall_s1) begin
				valid_s1 <= up_valid;
			end
			if (!stall_s2) begin
				valid_s2 <= valid_s1;
			end
			if (!stall_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s1 && up_valid) begin
			ct_s1 <= tth.c;
			st_s1 <= tth.s;
			ca_s1 <= tal.c;
			sa_s1 <= tal.s;
			r_s1  <= up_side.r;
			d_s1  <= up_side.d;
		end
		if (!stall_s2 && valid_s1) begin
			stca_s2 <= PR_W'(st_s1) * PR_W'(ca_s1);
			stsa_s2 <= PR_W'(st_s1) * PR_W'(sa_s1);
			ctca_s2 <= PR_W'(ct_s1) * PR_W'(ca_s1);
			ctsa_s2 <= PR_W'(ct_s1) * PR_W'(sa_s1);
			tx_s2   <= TP_W'(r_s1) * TP_W'(ct_s1);
			ty_s2   <= TP_W'(r_s1) * TP_W'(st_s1);
			ct_s2   <= ct_s1;
			st_s2   <= st_s1;
			ca_s2   <= ca_s1;
			sa_s2   <= sa_s1;
			d_s2    <= d_s1;
		end
		if (!stall_s3 && valid_s2) begin
			r00_s3 <= sgl_round(ct_s2);
			r01_s3 <= prod_round(stca_s2, 1'b1);
			r02_s3 <= prod_round(stsa_s2, 1'b0);
			tx_s3  <= trans_round(tx_s2);
			r10_s3 <= sgl_round(st_s2);
			r11_s3 <= prod_round(ctca_s2, 1'b0);
			r12_s3 <= prod_round(ctsa_s2, 1'b1);
			ty_s3  <= trans_round(ty_s2);
			r21_s3 <= sgl_round(sa_s2);
			r22_s3 <= sgl_round(ca_s2);
			tz_s3  <= d_s2;
		end
	end

	assign dn_valid  = valid_s3;
	assign row0_col0 = r00_s3;
	assign row0_col1 = r01_s3;
	assign row0_col2 = r02_s3;
	assign trans_x   = tx_s3;
	assign row1_col0 = r10_s3;
	assign row1_col1 = r11_s3;
	assign row1_col2 = r12_s3;
	assign trans_y   = ty_s3;
	assign row2_col1 = r21_s3;
	assign row2_col2 = r22_s3;
	assign trans_z   = tz_s3;

endmodule

// ===== rtl/dh_link_transform_core.sv =====
// dh_link_transform_core: denavit-hartenberg link transform, top level
// depends on dhlt_pkg, dhlt_angle_reduce, dhlt_cordic_cell, dhlt_matrix_out
//
// usage
//   input channel: one word per link, theta and alpha in 1/128 degree, r and d in q16.16;
//   a word is taken on a clock edge with in_valid high and in_stall low
//   output channel: one word per input word, eight rotation terms in q2.14 and three
//   translations in q16.16, taken on an edge with out_valid high and out_stall low
//   stages: angle reduction, one cordic cell per micro-rotation, then quadrant
//   fix-up, multiply, round
//   throughput: one word per cycle while out_stall is low; every stage holds one
//   word and moves it on whenever the next stage is empty or moving
//   stall: a stalled output holds its word; the stall backs up stage by stage, and
//   in_stall rises only once every stage holds a word
//   reset: arst_n low empties the pipeline at once, dropping any words in flight
`timescale 1ns / 1ps

module dh_link_transform_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [dhlt_pkg::ANG_W-1:0]  theta_angle,
	input  logic signed [dhlt_pkg::ANG_W-1:0]  alpha_angle,
	input  logic signed [dhlt_pkg::FX_W-1:0]   link_offset,
	input  logic signed [dhlt_pkg::FX_W-1:0]   link_height,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [dhlt_pkg::Q14_W-1:0]  row0_col0,
	output logic signed [dhlt_pkg::Q14_W-1:0]  row0_col1,
	output logic signed [dhlt_pkg::Q14_W-1:0]  row0_col2,
	output logic signed [dhlt_pkg::FX_W-1:0]   trans_x,
	output logic signed [dhlt_pkg::Q14_W-1:0]  row1_col0,
	output logic signed [dhlt_pkg::Q14_W-1:0]  row1_col1,
	output logic signed [dhlt_pkg::Q14_W-1:0]  row1_col2,
	output logic signed [dhlt_pkg::FX_W-1:0]   trans_y,
	output logic signed [dhlt_pkg::Q14_W-1:0]  row2_col1,
	output logic signed [dhlt_pkg::Q14_W-1:0]  row2_col2,
	output logic signed [dhlt_pkg::FX_W-1:0]   trans_z
);
	import dhlt_pkg::*;

	logic  vld_w [N_STEPS+1];
	logic  stl_w [N_STEPS+1];
	rot_t  th_w  [N_STEPS+1];
	rot_t  al_w  [N_STEPS+1];
	side_t side_w[N_STEPS+1];

	dhlt_angle_reduce u_reduce (
		.clk         (clk),
		.arst_n      (arst_n),
		.up_valid    (in_valid),
		.up_stall    (in_stall),
		.theta_angle (theta_angle),
		.alpha_angle (alpha_angle),
		.link_offset (link_offset),
		.link_height (link_height),
		.dn_valid    (vld_w[0]),
		.dn_stall    (stl_w[0]),
		.dn_th       (th_w[0]),
		.dn_al       (al_w[0]),
		.dn_side     (side_w[0])
	);

	for (genvar g = 0; g < N_STEPS; g++) begin : g_cell
		localparam logic [SH_W-1:0]       SHAMT = SH_W'(g);
		localparam logic signed [Z_W-1:0] ATAN  = Z_W'(atan_step(g));

		dhlt_cordic_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shamt    (SHAMT),
			.atan     (ATAN),
			.up_valid (vld_w[g]),
			.up_stall (stl_w[g]),
			.up_th    (th_w[g]),
			.up_al    (al_w[g]),
			.up_side  (side_w[g]),
			.dn_valid (vld_w[g+1]),
			.dn_stall (stl_w[g+1]),
			.dn_th    (th_w[g+1]),
			.dn_al    (al_w[g+1]),
			.dn_side  (side_w[g+1])
		);
	end

	dhlt_matrix_out u_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (vld_w[N_STEPS]),
		.up_stall  (stl_w[N_STEPS]),
		.up_th     (th_w[N_STEPS]),
		.up_al     (al_w[N_STEPS]),
		.up_side   (side_w[N_STEPS]),
		.dn_valid  (out_valid),
		.dn_stall  (out_stall),
		.row0_col0 (row0_col0),
		.row0_col1 (row0_col1),
		.row0_col2 (row0_col2),
		.trans_x   (trans_x),
		.row1_col0 (row1_col0),
		.row1_col1 (row1_col1),
		.row1_col2 (row1_col2),
		.trans_y   (trans_y),
		.row2_col1 (row2_col1),
		.row2_col2 (row2_col2),
		.trans_z   (trans_z)
	);

endmodule

// ===== rtl/dhlt_checker.sv =====
// dhlt_checker: port-level checks on the link transform, bound to the top level
// depends on dh_link_transform_core ports only
`timescale 1ns / 1ps

module dhlt_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic signed [15:0]  row0_col0,
	input logic signed [15:0]  row1_col1,
	input logic signed [15:0]  row2_col2,
	input logic signed [31:0]  trans_x,
	input logic signed [31:0]  trans_z
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(row0_col0) && $stable(trans_x)
			&& $stable(trans_z))
		else $error("stalled output word changed");

	// an empty output stage leaves room all the way back to the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output stage");

	// the three diagonal rotation terms stay within plus or minus one
	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> row0_col0 <= 16'sd16384 && row0_col0 >= -16'sd16384
			&& row1_col1 <= 16'sd16384 && row1_col1 >= -16'sd16384
			&& row2_col2 <= 16'sd16384 && row2_col2 >= -16'sd16384)
		else $error("rotation term out of range");

	// the pipeline is empty right after reset
	a_reset_empty: assert property (@(posedge clk)
		!$past(arst_n) |-> !out_valid || arst_n)
		else $error("output valid straight after reset");

endmodule

bind dh_link_transform_core dhlt_checker u_dhlt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.row0_col0 (row0_col0),
	.row1_col1 (row1_col1),
	.row2_col2 (row2_col2),
	.trans_x   (trans_x),
	.trans_z   (trans_z)
);

// ===== test/dh_link_transform_checker.sv =====
// dh_link_transform_checker: watches both channels of dh_link_transform_core, predicts every
// result word in fixed point and compares it field by field; depends on dhlt_pkg
`timescale 1ns / 1ps

module dh_link_transform_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic signed [dhlt_pkg::ANG_W-1:0]  theta_angle,
	input  logic signed [dhlt_pkg::ANG_W-1:0]  alpha_angle,
	input  logic signed [dhlt_pkg::FX_W-1:0]   link_offset,
	input  logic signed [dhlt_pkg::FX_W-1:0]   link_height,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic signed [dhlt_pkg::Q14_W-1:0]  row0_col0,
	input  logic signed [dhlt_pkg::Q14_W-1:0]  row0_col1,
	input  logic signed [dhlt_pkg::Q14_W-1:0]  row0_col2,
	input  logic signed [dhlt_pkg::FX_W-1:0]   trans_x,
	input  logic signed [dhlt_pkg::Q14_W-1:0]  row1_col0,
	input  logic signed [dhlt_pkg::Q14_W-1:0]  row1_col1,
	input  logic signed [dhlt_pkg::Q14_W-1:0]  row1_col2,
	input  logic signed [dhlt_pkg::FX_W-1:0]   trans_y,
	input  logic signed [dhlt_pkg::Q14_W-1:0]  row2_col1,
	input  logic signed [dhlt_pkg::Q14_W-1:0]  row2_col2,
	input  logic signed [dhlt_pkg::FX_W-1:0]   trans_z,
	output int                                 fail_count,
	output int                                 pending
);
	import dhlt_pkg::*;

	localparam int     FRAC        = TRIG_FRAC_BITS;
	localparam longint UNIT        = longint'(1) << FRAC;
	localparam longint TURN        = 46080;
	localparam longint QUARTER     = 11520;
	localparam longint EIGHTH      = 5760;
	localparam longint DEG_SCALE   = 64'd7690109350;
	localparam longint CORDIC_GAIN = 64'd2608131496;
	localparam longint Q14_LIMIT   = 16384;
	localparam longint FX_LO       = -(longint'(1) << 31);
	localparam longint FX_HI       = (longint'(1) << 31) - 1;

	typedef struct {
		logic signed [Q14_W-1:0] row0_col0;
		logic signed [Q14_W-1:0] row0_col1;
		logic signed [Q14_W-1:0] row0_col2;
		logic signed [FX_W-1:0]  trans_x;
		logic signed [Q14_W-1:0] row1_col0;
		logic signed [Q14_W-1:0] row1_col1;
		logic signed [Q14_W-1:0] row1_col2;
		logic signed [FX_W-1:0]  trans_y;
		logic signed [Q14_W-1:0] row2_col1;
		logic signed [Q14_W-1:0] row2_col2;
		logic signed [FX_W-1:0]  trans_z;
	} link_frame_t;

	longint      arc_table [FRAC+2];
	link_frame_t frames_due [$];
	int          errors    = 0;
	int          due_count = 0;

	assign fail_count = errors;
	assign pending    = due_count;

	// arctangent of 2^-i in degrees * 2^27, from its odd power series
	function automatic longint arc_entry(input int i);
		longint series;
		longint part;
		series = 0;
		if (i == 0) begin
			return longint'(45) << 27;
		end
		for (int k = 1; k * i < 64; k += 2) begin
			part = ((DEG_SCALE << 24) >>> (k * i)) / longint'(k);
			if (((k - 1) / 2) % 2 == 1) begin
				series -= part;
			end else begin
				series += part;
			end
		end
		return series >>> 24;
	endfunction

	initial begin
		for (int i = 0; i < FRAC + 2; i++) begin
			arc_table[i] = arc_entry(i);
		end
	end

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint round_half_up(input longint v, input int s);
		if (s == 0) begin
			return v;
		end
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic void unit_vector(input longint ang, output longint c, output longint s);
		longint a;
		longint rem;
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		longint cc;
		longint ss;
		int     q;
		quad_t  quad;
		a = ang % TURN;
		if (a < 0) begin
			a += TURN;
		end
		q   = int'(a / QUARTER);
		rem = a - longint'(q) * QUARTER;
		if (rem > EIGHTH) begin
			rem -= QUARTER;
			q++;
		end
		quad = quad_t'(q[1:0]);
		if (rem == 0) begin
			cc = UNIT;
			ss = 0;
		end else begin
			x = (CORDIC_GAIN + (longint'(1) << (31 - FRAC))) >>> (32 - FRAC);
			y = 0;
			z = rem <<< 20;
			for (int i = 0; i < FRAC + 2; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= arc_table[i];
				end else begin
					x += dx;
					y -= dy;
					z += arc_table[i];
				end
			end
			cc = clip(x, -UNIT, UNIT);
			ss = clip(y, -UNIT, UNIT);
		end
		case (quad)
			QUAD_0: begin
				c = cc;
				s = ss;
			end
			QUAD_90: begin
				c = -ss;
				s = cc;
			end
			QUAD_180: begin
				c = -cc;
				s = -ss;
			end
			default: begin
				c = ss;
				s = -cc;
			end
		endcase
	endfunction

	function automatic longint single_q14(input longint v);
		longint o;
		if (FRAC >= 14) begin
			o = round_half_up(v, FRAC - 14);
		end else begin
			o = v <<< (14 - FRAC);
		end
		return clip(o, -Q14_LIMIT, Q14_LIMIT);
	endfunction

	function automatic longint product_q14(input longint a, input longint b);
		return clip(round_half_up(a * b, 2 * FRAC - 14), -Q14_LIMIT, Q14_LIMIT);
	endfunction

	function automatic longint scaled_offset(input longint r, input longint t);
		return clip(round_half_up(r * t, FRAC), FX_LO, FX_HI);
	endfunction

	function automatic link_frame_t predict_frame(input logic signed [ANG_W-1:0] th, al,
			input logic signed [FX_W-1:0] r, d);
		link_frame_t f;
		longint      ct;
		longint      st;
		longint      ca;
		longint      sa;
		unit_vector(longint'(th), ct, st);
		unit_vector(longint'(al), ca, sa);
		f.row0_col0 = Q14_W'(single_q14(ct));
		f.row0_col1 = Q14_W'(product_q14(-st, ca));
		f.row0_col2 = Q14_W'(product_q14(st, sa));
		f.trans_x   = FX_W'(scaled_offset(longint'(r), ct));
		f.row1_col0 = Q14_W'(single_q14(st));
		f.row1_col1 = Q14_W'(product_q14(ct, ca));
		f.row1_col2 = Q14_W'(product_q14(-ct, sa));
		f.trans_y   = FX_W'(scaled_offset(longint'(r), st));
		f.row2_col1 = Q14_W'(single_q14(sa));
		f.row2_col2 = Q14_W'(single_q14(ca));
		f.trans_z   = d;
		return f;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		link_frame_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				frames_due.push_back(predict_frame(theta_angle, alpha_angle,
					link_offset, link_height));
			end
			if (out_valid && !out_stall) begin
				if (frames_due.size() == 0) begin
					$error("result word with no link pending");
					errors++;
				end else begin
					want = frames_due.pop_front();
					check_field("row0_col0", want.row0_col0, row0_col0);
					check_field("row0_col1", want.row0_col1, row0_col1);
					check_field("row0_col2", want.row0_col2, row0_col2);
					check_field("trans_x", want.trans_x, trans_x);
					check_field("row1_col0", want.row1_col0, row1_col0);
					check_field("row1_col1", want.row1_col1, row1_col1);
					check_field("row1_col2", want.row1_col2, row1_col2);
					check_field("trans_y", want.trans_y, trans_y);
					check_field("row2_col1", want.row2_col1, row2_col1);
					check_field("row2_col2", want.row2_col2, row2_col2);
					check_field("trans_z", want.trans_z, trans_z);
				end
			end
			due_count <= frames_due.size();
		end
	end

endmodule

// ===== test/dh_link_transform_core_tb.sv =====
// dh_link_transform_core_tb: drives link words into dh_link_transform_core with random gaps
// and output stalls; depends on dhlt_pkg, dh_link_transform_core, dh_link_transform_checker
`timescale 1ns / 1ps

module dh_link_transform_core_tb;
	import dhlt_pkg::*;

	localparam int                    N_RANDOM     = 1700;
	localparam int                    DRAIN_CYCLES = 40;
	localparam int                    LIMIT_CYCLES = 200000;
	localparam logic signed [FX_W-1:0] FX_MIN      = 32'sh8000_0000;
	localparam logic signed [FX_W-1:0] FX_MAX      = 32'sh7fff_ffff;

	logic                    clk         = 1'b0;
	logic                    arst_n      = 1'b0;
	logic                    in_valid    = 1'b0;
	logic                    out_stall   = 1'b0;
	logic                    quiet       = 1'b0;
	logic signed [ANG_W-1:0] theta_angle = '0;
	logic signed [ANG_W-1:0] alpha_angle = '0;
	logic signed [FX_W-1:0]  link_offset = '0;
	logic signed [FX_W-1:0]  link_height = '0;
	logic                    in_stall;
	logic                    out_valid;
	logic signed [Q14_W-1:0] row0_col0;
	logic signed [Q14_W-1:0] row0_col1;
	logic signed [Q14_W-1:0] row0_col2;
	logic signed [FX_W-1:0]  trans_x;
	logic signed [Q14_W-1:0] row1_col0;
	logic signed [Q14_W-1:0] row1_col1;
	logic signed [Q14_W-1:0] row1_col2;
	logic signed [FX_W-1:0]  trans_y;
	logic signed [Q14_W-1:0] row2_col1;
	logic signed [Q14_W-1:0] row2_col2;
	logic signed [FX_W-1:0]  trans_z;
	int                      fail_count;
	int                      pending;

	dh_link_transform_core dut (.*);

	dh_link_transform_checker link_check (.*);

	always begin
		#6;
		clk = 1'b1;
		#6;
		clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < 8);
	end

	task automatic send_link(input logic signed [ANG_W-1:0] th, al,
			input logic signed [FX_W-1:0] r, d);
		while (!quiet && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		theta_angle <= th;
		alpha_angle <= al;
		link_offset <= r;
		link_height <= d;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	function automatic logic signed [ANG_W-1:0] pick_angle();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 35) begin
			return ANG_W'($urandom);
		end
		if (sel < 65) begin
			return ANG_W'($signed($urandom_range(92160)) - 46080);
		end
		if (sel < 80) begin
			return ANG_W'(($signed($urandom_range(10)) - 5) * 11520);
		end
		// near quarter and eighth turn boundaries
		return ANG_W'(($signed($urandom_range(16)) - 8) * 5760 + $signed($urandom_range(6)) - 3);
	endfunction

	function automatic logic signed [FX_W-1:0] pick_fixed();
		case ($urandom_range(9))
			0: return FX_MIN;
			1: return FX_MAX;
			2: return FX_W'($signed($urandom_range(131072)) - 65536);
			default: return FX_W'($urandom);
		endcase
	endfunction

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_link(0, 0, 65536, 0);
		send_link(11520, -11520, FX_MIN, FX_MAX);
		send_link(23040, 23040, FX_MIN, FX_MIN);
		send_link(-11520, 34560, FX_MIN, -1);
		send_link(-23040, -23040, FX_MAX, 1);
		send_link(46080, -46080, FX_MAX, 0);
		send_link(34560, -34560, 65536, 12345);
		send_link(5760, -5760, FX_MAX, FX_MIN);
		send_link(5761, -5761, FX_MIN, FX_MAX);
		send_link(-5760, 5759, 196608, -65536);
		send_link(65535, -65536, FX_MAX, FX_MAX);
		send_link(46081, -46081, -65536, 7);
		send_link(1, -1, 1, -1);
		send_link(11519, 17281, 100000, -100000);
		send_link(3840, 7680, 131072, 0);
		send_link(-65535, 57600, FX_MIN, 0);

		for (int n = 0; n < N_RANDOM; n++) begin
			quiet <= (n >= 700 && n < 1000);
			// hold off until the pipeline has drained
			if (n % 500 == 250) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) begin
					@(posedge clk);
				end
			end
			send_link(pick_angle(), pick_angle(), pick_fixed(), pick_fixed());
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * 12);
		$display("Test completed with failures");
		$finish;
	end

endmodule
